[rtl/core/rhtt_pkg.sv]
// Shared types, codes and constants for the rectangle hit-test table.
package rhtt_pkg;

  localparam int COORD_W  = 32;
  localparam int SIZE_W   = 31;
  localparam int TAG_W    = 16;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;

  localparam int MAX_RECTS_DEF = 32;
  localparam int TAG_BITS_DEF  = 16;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_HIT    = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_RSVD   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_NONE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    JOB_INSERT,
    JOB_HIT,
    JOB_QUERY,
    JOB_NONE
  } job_kind_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_DONE
  } back_state_t;

  typedef struct packed {
    logic [CMD_W-1:0]          command;
    logic [TAG_W-1:0]          element_tag;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic [SIZE_W-1:0]         size_w;
    logic [SIZE_W-1:0]         size_h;
    logic signed [COORD_W-1:0] corner2_x;
    logic signed [COORD_W-1:0] corner2_y;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TAG_W-1:0]    match_tag;
    logic                last;
  } out_item_t;

  // Classified work item. Hit test: (ax, ay) is the point.
  // Query: ax/bx and ay/by are the ordered low/high bounds.
  typedef struct packed {
    job_kind_t                 kind;
    logic [TAG_W-1:0]          tag;
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
    logic [SIZE_W-1:0]         w;
    logic [SIZE_W-1:0]         h;
  } job_t;

endpackage

[rtl/core/rectangle_hit_test_table_unit.sv]
// Rectangle hit-test table: top level tying front end, job queue and scan engine.
//
// Input channel (in_valid / in_stall / in_item): one beat is one command:
// insert a rectangle, point hit test, or rectangle overlap query. A beat is
// taken on a rising edge with in_valid high and in_stall low.
// Result channel (out_valid / out_stall / out_item): one or more beats per
// command; the final beat of a command has last set.
// The front end decodes each command and orders query corners, then parks it
// in a two-entry queue, so up to two commands are taken while the engine is
// busy. The engine handles one command at a time.
// Insert and unused codes go from idle through the done state, which
// registers their single result beat. Hit test and query read the table one
// entry per cycle, while the result side does not stall, from a RAM with
// registered read; the engine takes no new command until the final beat of
// the current one is emitted. A hit test ends early at its first hit.
// Out_stall freezes the result register; the scan waits on the entry it
// holds and resumes where it stopped, nothing is lost or repeated.
// Reset empties the table and the queue; no clearing pass is needed.
module rectangle_hit_test_table_unit #(
  parameter int MAX_RECTS = rhtt_pkg::MAX_RECTS_DEF,
  parameter int TAG_BITS  = rhtt_pkg::TAG_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rhtt_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output rhtt_pkg::out_item_t out_item
);

  logic           q_full, q_empty, push, pop;
  rhtt_pkg::job_t push_job, pop_job;

  rhtt_front u_front (
    .in_valid (in_valid),
    .in_item  (in_item),
    .in_stall (in_stall),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  rhtt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  rhtt_back #(
    .MAX_RECTS (MAX_RECTS),
    .TAG_BITS  (TAG_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (!q_empty),
    .job       (pop_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

[rtl/core/rhtt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module rhtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/rhtt_front.sv]
// Front end: accepts input beats, decodes the command and orders query corners.
module rhtt_front (
  input  logic              in_valid,
  input  rhtt_pkg::in_item_t in_item,
  output logic              in_stall,
  input  logic              q_full,
  output logic              push,
  output rhtt_pkg::job_t    push_job
);

  logic signed [rhtt_pkg::COORD_W-1:0] lo_x, hi_x, lo_y, hi_y;

  always_comb begin
    if (in_item.pos_x < in_item.corner2_x) begin
      lo_x = in_item.pos_x;
      hi_x = in_item.corner2_x;
    end else begin
      lo_x = in_item.corner2_x;
      hi_x = in_item.pos_x;
    end
    if (in_item.pos_y < in_item.corner2_y) begin
      lo_y = in_item.pos_y;
      hi_y = in_item.corner2_y;
    end else begin
      lo_y = in_item.corner2_y;
      hi_y = in_item.pos_y;
    end
  end

  always_comb begin
    push_job.tag = in_item.element_tag;
    push_job.w   = in_item.size_w;
    push_job.h   = in_item.size_h;
    push_job.ax  = in_item.pos_x;
    push_job.ay  = in_item.pos_y;
    push_job.bx  = in_item.corner2_x;
    push_job.by  = in_item.corner2_y;
    case (in_item.command)
      rhtt_pkg::CMD_INSERT: begin
        push_job.kind = rhtt_pkg::JOB_INSERT;
      end
      rhtt_pkg::CMD_HIT: begin
        push_job.kind = rhtt_pkg::JOB_HIT;
      end
      rhtt_pkg::CMD_QUERY: begin
        push_job.kind = rhtt_pkg::JOB_QUERY;
        push_job.ax   = lo_x;
        push_job.ay   = lo_y;
        push_job.bx   = hi_x;
        push_job.by   = hi_y;
      end
      default: begin
        push_job.kind = rhtt_pkg::JOB_NONE;
      end
    endcase
  end

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

endmodule

[rtl/core/rhtt_queue.sv]
// Small job queue between the front end and the scan engine.
module rhtt_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rhtt_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output rhtt_pkg::job_t pop_job,
  output logic           empty
);

  localparam int PTR_W = (rhtt_pkg::QUEUE_DEPTH > 1) ? $clog2(rhtt_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(rhtt_pkg::QUEUE_DEPTH + 1);

  rhtt_pkg::job_t   slot_r [rhtt_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(rhtt_pkg::QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  assign full    = (count_r == CNT_W'(rhtt_pkg::QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign pop_job = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (!push && pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

[rtl/core/rhtt_back.sv]
// Back end: stores rectangles and scans the table for hit tests and queries.
module rhtt_back #(
  parameter int MAX_RECTS = rhtt_pkg::MAX_RECTS_DEF,
  parameter int TAG_BITS  = rhtt_pkg::TAG_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_valid,
  input  rhtt_pkg::job_t      job,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output rhtt_pkg::out_item_t out_item
);

  localparam int CNT_W   = $clog2(MAX_RECTS + 1);
  localparam int IDX_W   = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int CW      = rhtt_pkg::COORD_W;
  localparam int SW      = rhtt_pkg::SIZE_W;
  localparam int ENTRY_W = TAG_BITS + 2 * CW + 2 * SW;
  // entry layout, low to high: height, width, top, left, tag
  localparam int H_LO = 0;
  localparam int W_LO = SW;
  localparam int T_LO = 2 * SW;
  localparam int L_LO = 2 * SW + CW;
  localparam int G_LO = 2 * SW + 2 * CW;

  rhtt_pkg::back_state_t state_r, state_nxt;
  rhtt_pkg::job_t        job_r, job_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [CNT_W-1:0]      issue_r, issue_nxt;
  logic                  chk_v_r, chk_v_nxt;
  logic [IDX_W-1:0]      chk_idx_r, chk_idx_nxt;
  logic                  held_v_r, held_v_nxt;
  logic [rhtt_pkg::TAG_W-1:0] held_tag_r, held_tag_nxt;
  logic                  ins_ok_r, ins_ok_nxt;
  logic                  out_valid_r, out_valid_nxt;
  rhtt_pkg::out_item_t   out_item_r, out_item_nxt;

  logic                  we;
  logic [IDX_W-1:0]      waddr, raddr;
  logic [ENTRY_W-1:0]    wdata, rdata;

  logic                  can_emit, emit_en;
  rhtt_pkg::out_item_t   emit_item;
  logic [31:0]           tag_in_ext, tag_rd_ext;
  logic [rhtt_pkg::TAG_W-1:0] rd_tag;
  logic signed [CW:0]    r_left, r_top, r_right, r_bottom;
  logic signed [CW:0]    a_x, a_y, b_x, b_y;
  logic                  in_hit, overlap, match, more, is_hit, emit_need;
  logic [CNT_W-1:0]      issue_full;
  logic [IDX_W-1:0]      issue_idx;

  rhtt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_RECTS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign can_emit = !out_valid_r || !out_stall;
  assign is_hit   = (job_r.kind == rhtt_pkg::JOB_HIT);
  assign more     = (issue_r != cnt_r);

  // tags are kept in TAG_BITS bits and shown as 16 on the result
  assign tag_in_ext = {16'b0, job.tag};
  assign tag_rd_ext = 32'(rdata[G_LO +: TAG_BITS]);
  assign rd_tag     = tag_rd_ext[rhtt_pkg::TAG_W-1:0];

  assign wdata = {tag_in_ext[TAG_BITS-1:0], job.ax, job.ay, job.w, job.h};

  // exact 33-bit edges, nothing wraps
  assign r_left   = $signed({rdata[L_LO+CW-1], rdata[L_LO +: CW]});
  assign r_top    = $signed({rdata[T_LO+CW-1], rdata[T_LO +: CW]});
  assign r_right  = r_left + $signed({2'b00, rdata[W_LO +: SW]});
  assign r_bottom = r_top + $signed({2'b00, rdata[H_LO +: SW]});
  assign a_x      = $signed({job_r.ax[CW-1], job_r.ax});
  assign a_y      = $signed({job_r.ay[CW-1], job_r.ay});
  assign b_x      = $signed({job_r.bx[CW-1], job_r.bx});
  assign b_y      = $signed({job_r.by[CW-1], job_r.by});

  assign in_hit  = (a_x >= r_left) && (a_x <= r_right) && (a_y >= r_top) && (a_y <= r_bottom);
  assign overlap = (r_left < b_x) && (r_right > a_x) && (r_top < b_y) && (r_bottom > a_y);
  assign match   = chk_v_r && (is_hit ? in_hit : overlap);

  // hit test walks newest to oldest, query oldest to newest
  assign issue_full = is_hit ? (cnt_r - issue_r - CNT_W'(1)) : issue_r;
  assign issue_idx  = issue_full[IDX_W-1:0];
  assign emit_need  = match && (is_hit || held_v_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rhtt_pkg::B_IDLE: begin
        if (job_valid) begin
          if (job.kind == rhtt_pkg::JOB_HIT || job.kind == rhtt_pkg::JOB_QUERY) begin
            state_nxt = rhtt_pkg::B_SCAN;
          end else begin
            state_nxt = rhtt_pkg::B_DONE;
          end
        end
      end
      rhtt_pkg::B_SCAN: begin
        if (match && is_hit) begin
          if (can_emit) begin
            state_nxt = rhtt_pkg::B_IDLE;
          end
        end else if (!chk_v_r && !more) begin
          state_nxt = rhtt_pkg::B_DONE;
        end
      end
      rhtt_pkg::B_DONE: begin
        if (can_emit) begin
          state_nxt = rhtt_pkg::B_IDLE;
        end
      end
      default: begin
        state_nxt = rhtt_pkg::B_IDLE;
      end
    endcase
  end

  always_comb begin
    job_nxt      = job_r;
    cnt_nxt      = cnt_r;
    issue_nxt    = issue_r;
    chk_v_nxt    = chk_v_r;
    chk_idx_nxt  = chk_idx_r;
    held_v_nxt   = held_v_r;
    held_tag_nxt = held_tag_r;
    ins_ok_nxt   = ins_ok_r;
    pop          = 1'b0;
    we           = 1'b0;
    waddr        = cnt_r[IDX_W-1:0];
    raddr        = chk_idx_r;
    emit_en      = 1'b0;
    emit_item    = '{status: rhtt_pkg::ST_NONE, match_tag: '0, last: 1'b1};
    case (state_r)
      rhtt_pkg::B_IDLE: begin
        if (job_valid) begin
          pop        = 1'b1;
          job_nxt    = job;
          issue_nxt  = '0;
          chk_v_nxt  = 1'b0;
          held_v_nxt = 1'b0;
          if (job.kind == rhtt_pkg::JOB_INSERT) begin
            if (cnt_r == CNT_W'(MAX_RECTS)) begin
              ins_ok_nxt = 1'b0;
            end else begin
              ins_ok_nxt = 1'b1;
              we         = 1'b1;
              cnt_nxt    = cnt_r + CNT_W'(1);
            end
          end
        end
      end
      rhtt_pkg::B_SCAN: begin
        if (!(emit_need && !can_emit)) begin
          if (emit_need) begin
            emit_en = 1'b1;
            if (is_hit) begin
              emit_item = '{status: rhtt_pkg::ST_OK, match_tag: rd_tag, last: 1'b1};
            end else begin
              emit_item = '{status: rhtt_pkg::ST_OK, match_tag: held_tag_r, last: 1'b0};
            end
          end
          if (match && !is_hit) begin
            // hold one hit back so the final one can carry last
            held_v_nxt   = 1'b1;
            held_tag_nxt = rd_tag;
          end
          if (match && is_hit) begin
            chk_v_nxt = 1'b0;
          end else if (more) begin
            raddr       = issue_idx;
            chk_v_nxt   = 1'b1;
            chk_idx_nxt = issue_idx;
            issue_nxt   = issue_r + CNT_W'(1);
          end else begin
            chk_v_nxt = 1'b0;
          end
        end
        // on a stalled emit the same entry is read again
      end
      rhtt_pkg::B_DONE: begin
        if (can_emit) begin
          emit_en = 1'b1;
          if (job_r.kind == rhtt_pkg::JOB_QUERY && held_v_r) begin
            emit_item = '{status: rhtt_pkg::ST_OK, match_tag: held_tag_r, last: 1'b1};
          end else if (job_r.kind == rhtt_pkg::JOB_INSERT) begin
            emit_item = '{status: ins_ok_r ? rhtt_pkg::ST_OK : rhtt_pkg::ST_FULL,
                          match_tag: '0, last: 1'b1};
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (emit_en) begin
      out_valid_nxt = 1'b1;
      out_item_nxt  = emit_item;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    job_r        <= job_nxt;
    chk_idx_r    <= chk_idx_nxt;
    held_tag_r   <= held_tag_nxt;
    out_item_r   <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rhtt_pkg::B_IDLE;
      cnt_r       <= '0;
      issue_r     <= '0;
      chk_v_r     <= 1'b0;
      held_v_r    <= 1'b0;
      ins_ok_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      issue_r     <= issue_nxt;
      chk_v_r     <= chk_v_nxt;
      held_v_r    <= held_v_nxt;
      ins_ok_r    <= ins_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

[verif/rectangle_hit_test_table_checker.sv]
// Bench checker: watches both channels, predicts each command's answer and compares.
`timescale 1ns / 100ps

module rectangle_hit_test_table_checker #(
  parameter int TABLE_DEPTH = rhtt_pkg::MAX_RECTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  rhtt_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  logic                out_stall,
  input  rhtt_pkg::out_item_t out_item,
  output int                  mismatches,
  output int                  outstanding,
  output int                  hits_found,
  output int                  inserts_refused,
  output int                  widest_answer
);

  typedef struct {
    logic [rhtt_pkg::TAG_W-1:0]          tag;
    logic signed [rhtt_pkg::COORD_W-1:0] left;
    logic signed [rhtt_pkg::COORD_W-1:0] top;
    logic [rhtt_pkg::SIZE_W-1:0]         w;
    logic [rhtt_pkg::SIZE_W-1:0]         h;
  } placed_rect_t;

  placed_rect_t        rects [TABLE_DEPTH];
  int                  rect_count;
  rhtt_pkg::out_item_t answer_beats [$];
  rhtt_pkg::out_item_t due_beat;
  int                  err_count;
  int                  hit_count;
  int                  full_count;
  int                  widest;

  function automatic rhtt_pkg::out_item_t make_beat(
    input rhtt_pkg::status_t          st,
    input logic [rhtt_pkg::TAG_W-1:0] tag,
    input logic                       fin
  );
    rhtt_pkg::out_item_t b;
    b.status    = st;
    b.match_tag = tag;
    b.last      = fin;
    return b;
  endfunction

  // append one expected beat at the tail
  task automatic add_beat(input rhtt_pkg::out_item_t b);
    answer_beats.insert(answer_beats.size(), b);
  endtask

  // Edges are compared at 64 bits so left + width never wraps.
  task automatic answer_command(input rhtt_pkg::in_item_t it);
    longint px, py, qx, qy, lo_x, hi_x, lo_y, hi_y;
    longint l, t, r, b;
    logic [rhtt_pkg::TAG_W-1:0] overlaps [$];
    bit found;
    px = longint'($signed(it.pos_x));
    py = longint'($signed(it.pos_y));
    found = 1'b0;
    case (rhtt_pkg::cmd_t'(it.command))
      rhtt_pkg::CMD_INSERT: begin
        if (rect_count >= TABLE_DEPTH) begin
          add_beat(make_beat(rhtt_pkg::ST_FULL, '0, 1'b1));
          full_count++;
        end else begin
          rects[rect_count].tag  = it.element_tag;
          rects[rect_count].left = it.pos_x;
          rects[rect_count].top  = it.pos_y;
          rects[rect_count].w    = it.size_w;
          rects[rect_count].h    = it.size_h;
          rect_count++;
          add_beat(make_beat(rhtt_pkg::ST_OK, '0, 1'b1));
        end
      end
      rhtt_pkg::CMD_HIT: begin
        // newest first, edges inclusive
        for (int i = rect_count - 1; i >= 0 && !found; i--) begin
          l = longint'($signed(rects[i].left));
          t = longint'($signed(rects[i].top));
          r = l + longint'($unsigned(rects[i].w));
          b = t + longint'($unsigned(rects[i].h));
          if (px >= l && px <= r && py >= t && py <= b) begin
            found = 1'b1;
            add_beat(make_beat(rhtt_pkg::ST_OK, rects[i].tag, 1'b1));
            hit_count++;
          end
        end
        if (!found) add_beat(make_beat(rhtt_pkg::ST_NONE, '0, 1'b1));
      end
      rhtt_pkg::CMD_QUERY: begin
        qx = longint'($signed(it.corner2_x));
        qy = longint'($signed(it.corner2_y));
        lo_x = (px < qx) ? px : qx;
        hi_x = (px < qx) ? qx : px;
        lo_y = (py < qy) ? py : qy;
        hi_y = (py < qy) ? qy : py;
        for (int i = 0; i < rect_count; i++) begin
          l = longint'($signed(rects[i].left));
          t = longint'($signed(rects[i].top));
          r = l + longint'($unsigned(rects[i].w));
          b = t + longint'($unsigned(rects[i].h));
          if (l < hi_x && r > lo_x && t < hi_y && b > lo_y)
            overlaps.insert(overlaps.size(), rects[i].tag);
        end
        if (overlaps.size() == 0) begin
          add_beat(make_beat(rhtt_pkg::ST_NONE, '0, 1'b1));
        end else begin
          for (int k = 0; k < overlaps.size(); k++)
            add_beat(make_beat(rhtt_pkg::ST_OK, overlaps[k], k == overlaps.size() - 1));
          if (overlaps.size() > widest) widest = overlaps.size();
        end
      end
      default: begin
        add_beat(make_beat(rhtt_pkg::ST_NONE, '0, 1'b1));
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      rect_count = 0;
      answer_beats.delete();
      err_count  = 0;
      hit_count  = 0;
      full_count = 0;
      widest     = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (answer_beats.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("%0t: result beat with nothing pending: status=%0d tag=%h last=%b",
                     $time, out_item.status, out_item.match_tag, out_item.last);
        end else begin
          due_beat = answer_beats.pop_front();
          if (out_item.status !== due_beat.status || out_item.match_tag !== due_beat.match_tag ||
              out_item.last !== due_beat.last) begin
            err_count++;
            if (err_count <= 10)
              $display("%0t: mismatch, status/tag/last expected %0d/%h/%b, got %0d/%h/%b",
                       $time, due_beat.status, due_beat.match_tag, due_beat.last,
                       out_item.status, out_item.match_tag, out_item.last);
          end
        end
      end
      if (in_valid && !in_stall) answer_command(in_item);
    end
    mismatches      <= err_count;
    outstanding     <= answer_beats.size();
    hits_found      <= hit_count;
    inserts_refused <= full_count;
    widest_answer   <= widest;
  end

endmodule

[verif/rectangle_hit_test_table_unit_tb.sv]
// Top of the rectangle hit-test table bench: clock, reset, command stimulus and verdict.
`timescale 1ns / 100ps

module rectangle_hit_test_table_unit_tb;

  localparam int GAP_MAX      = 17;
  localparam int LONG_HOLD    = 300;
  localparam int RANDOM_ITEMS = 130;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  rhtt_pkg::in_item_t  in_item;
  logic                out_valid;
  logic                out_stall;
  rhtt_pkg::out_item_t out_item;

  int mismatches;
  int outstanding;
  int hits_found;
  int inserts_refused;
  int widest_answer;

  int items_sent;
  int sent_by_cmd [4];
  bit tx_eager;
  bit rx_eager;
  bit held_once;
  // corners of inserted rectangles, used to aim hit tests at edges
  logic signed [rhtt_pkg::COORD_W-1:0] aim_x [$];
  logic signed [rhtt_pkg::COORD_W-1:0] aim_y [$];

  rectangle_hit_test_table_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  rectangle_hit_test_table_checker #(
    .TABLE_DEPTH (rhtt_pkg::MAX_RECTS_DEF)
  ) answer_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_item         (in_item),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_item        (out_item),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .hits_found      (hits_found),
    .inserts_refused (inserts_refused),
    .widest_answer   (widest_answer)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic rhtt_pkg::in_item_t rect_cmd(
    input logic [rhtt_pkg::TAG_W-1:0]          tag,
    input logic signed [rhtt_pkg::COORD_W-1:0] x, y,
    input logic [rhtt_pkg::SIZE_W-1:0]         w, h
  );
    rhtt_pkg::in_item_t it;
    it.command     = rhtt_pkg::CMD_INSERT;
    it.element_tag = tag;
    it.pos_x       = x;
    it.pos_y       = y;
    it.size_w      = w;
    it.size_h      = h;
    it.corner2_x   = $urandom;
    it.corner2_y   = $urandom;
    return it;
  endfunction

  function automatic rhtt_pkg::in_item_t probe_cmd(
    input rhtt_pkg::cmd_t                      c,
    input logic signed [rhtt_pkg::COORD_W-1:0] x, y, x2, y2
  );
    rhtt_pkg::in_item_t it;
    logic [31:0] rnd_tag, rnd_w, rnd_h;
    rnd_tag        = $urandom;
    rnd_w          = $urandom;
    rnd_h          = $urandom;
    it.command     = c;
    it.element_tag = rnd_tag[rhtt_pkg::TAG_W-1:0];
    it.pos_x       = x;
    it.pos_y       = y;
    it.size_w      = rnd_w[rhtt_pkg::SIZE_W-1:0];
    it.size_h      = rnd_h[rhtt_pkg::SIZE_W-1:0];
    it.corner2_x   = x2;
    it.corner2_y   = y2;
    return it;
  endfunction

  function automatic logic signed [rhtt_pkg::COORD_W-1:0] pick_coord();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 85) return int'($urandom_range(0, 4000)) - 2000;
    if (sel < 95) return $urandom;
    return sel[0] ? 32'sh7FFF_FFFF : 32'sh8000_0000;
  endfunction

  function automatic logic [rhtt_pkg::SIZE_W-1:0] pick_size();
    int sel;
    logic [31:0] rnd;
    sel = $urandom_range(0, 99);
    if (sel < 80) begin
      rnd = $urandom_range(0, 1500);
      return rnd[rhtt_pkg::SIZE_W-1:0];
    end
    if (sel < 90) return '0;
    rnd = $urandom;
    return rnd[rhtt_pkg::SIZE_W-1:0];
  endfunction

  // Mostly small-area rectangles so hits and overlaps are common.
  function automatic rhtt_pkg::in_item_t random_item();
    rhtt_pkg::in_item_t it;
    int sel;
    int k;
    logic [31:0] rnd_tag;
    logic signed [rhtt_pkg::COORD_W-1:0] x, y, x2, y2;
    logic [rhtt_pkg::SIZE_W-1:0] w, h;
    sel = $urandom_range(0, 99);
    x = pick_coord();
    y = pick_coord();
    if (sel < 30) begin
      w = pick_size();
      h = pick_size();
      rnd_tag = $urandom;
      it = rect_cmd(rnd_tag[rhtt_pkg::TAG_W-1:0], x, y, w, h);
      aim_x.insert(aim_x.size(), x);
      aim_y.insert(aim_y.size(), y);
      aim_x.insert(aim_x.size(), x + $signed({1'b0, w}));
      aim_y.insert(aim_y.size(), y + $signed({1'b0, h}));
    end else if (sel < 65) begin
      if (aim_x.size() > 0 && $urandom_range(0, 1) == 1) begin
        k = $urandom_range(0, aim_x.size() - 1);
        x = aim_x[k];
        y = aim_y[k];
      end
      it = probe_cmd(rhtt_pkg::CMD_HIT, x, y, $urandom, $urandom);
    end else if (sel < 95) begin
      k = $urandom_range(0, 9);
      if (k < 7) begin
        x2 = x + (int'($urandom_range(0, 3000)) - 1500);
        y2 = y + (int'($urandom_range(0, 3000)) - 1500);
      end else if (k < 9) begin
        x2 = pick_coord();
        y2 = pick_coord();
      end else begin
        // flat area, one shared coordinate
        x2 = $urandom_range(0, 1) ? x : pick_coord();
        y2 = (x2 == x) ? pick_coord() : y;
      end
      it = probe_cmd(rhtt_pkg::CMD_QUERY, x, y, x2, y2);
    end else begin
      it = probe_cmd(rhtt_pkg::CMD_RSVD, $urandom, $urandom, $urandom, $urandom);
    end
    return it;
  endfunction

  task automatic send_item(input rhtt_pkg::in_item_t it);
    int gap;
    if ($urandom_range(0, 15) == 0) tx_eager = !tx_eager;
    gap = tx_eager ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    items_sent++;
    sent_by_cmd[it.command]++;
  endtask

  // hold the sender until every pending beat has come back
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_item    <= '0;
    items_sent = 0;
    tx_eager   = 1'b0;
    foreach (sent_by_cmd[i]) sent_by_cmd[i] = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table, unused code
    send_item(probe_cmd(rhtt_pkg::CMD_HIT, 32'sd0, 32'sd0, 32'sd0, 32'sd0));
    send_item(probe_cmd(rhtt_pkg::CMD_QUERY, -32'sd5, -32'sd5, 32'sd5, 32'sd5));
    send_item(probe_cmd(rhtt_pkg::CMD_RSVD, $urandom, $urandom, $urandom, $urandom));
    // extreme rectangles: right edge past 32 bits, zero size at the minimum corner
    send_item(rect_cmd(16'hFFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF));
    send_item(rect_cmd(16'h0000, 32'sh8000_0000, 32'sh8000_0000, '0, '0));
    send_item(rect_cmd(16'h1234, -32'sd100, -32'sd100, 31'd200, 31'd200));
    send_item(rect_cmd(16'h00A5, 32'sd50, 32'sd50, '0, '0));
    send_item(rect_cmd(16'h5A5A, 32'sd0, 32'sd0, 31'd100, 31'd50));
    send_item(probe_cmd(rhtt_pkg::CMD_HIT, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, '0, '0));
    send_item(probe_cmd(rhtt_pkg::CMD_HIT, 32'sh8000_0000, 32'sh8000_0000, '0, '0));
    send_item(probe_cmd(rhtt_pkg::CMD_HIT, 32'sd50, 32'sd50, '0, '0));
    send_item(probe_cmd(rhtt_pkg::CMD_HIT, 32'sd100, 32'sd50, '0, '0));
    send_item(probe_cmd(rhtt_pkg::CMD_HIT, -32'sd100, 32'sd100, '0, '0));
    send_item(probe_cmd(rhtt_pkg::CMD_HIT, 32'sd101, 32'sd0, '0, '0));
    send_item(probe_cmd(rhtt_pkg::CMD_HIT, 32'sh7FFF_FFFF, 32'sh8000_0000, '0, '0));
    send_item(probe_cmd(rhtt_pkg::CMD_QUERY, -32'sd1000, -32'sd1000, 32'sd1000, 32'sd1000));
    send_item(probe_cmd(rhtt_pkg::CMD_QUERY, 32'sd1000, 32'sd1000, -32'sd1000, -32'sd1000));
    send_item(probe_cmd(rhtt_pkg::CMD_QUERY, 32'sd10, -32'sd1000, 32'sd10, 32'sd1000));
    send_item(probe_cmd(rhtt_pkg::CMD_QUERY, 32'sh8000_0000, 32'sh8000_0000,
                        32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
    // touching edges only
    send_item(probe_cmd(rhtt_pkg::CMD_QUERY, 32'sd100, 32'sd0, 32'sd200, 32'sd50));
    send_item(probe_cmd(rhtt_pkg::CMD_RSVD, 32'shFFFF_FFFF, 32'shFFFF_FFFF,
                        32'shFFFF_FFFF, 32'shFFFF_FFFF));
    settle();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 95) settle();
      send_item(random_item());
    end
    settle();
    repeat (40) @(posedge clk);

    $display("Ran %0d commands: %0d inserts, %0d hit tests, %0d area queries, %0d unused.",
             items_sent, sent_by_cmd[rhtt_pkg::CMD_INSERT], sent_by_cmd[rhtt_pkg::CMD_HIT],
             sent_by_cmd[rhtt_pkg::CMD_QUERY], sent_by_cmd[rhtt_pkg::CMD_RSVD]);
    $display("%0d hit tests found a rectangle, %0d inserts met a full table, widest %0d beats.",
             hits_found, inserts_refused, widest_answer);
    if (mismatches == 0)
      $display("rectangle_hit_test_table_unit_tb: done, clean");
    else
      $display("rectangle_hit_test_table_unit_tb: done, errors");
    $finish;
  end

  // Result side: random stall per beat, one long hold once the sender is well along.
  initial begin
    int gap;
    out_stall <= 1'b1;
    rx_eager  = 1'b0;
    held_once = 1'b0;
    gap       = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      repeat (gap) @(posedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      if ($urandom_range(0, 15) == 0) rx_eager = !rx_eager;
      if (!held_once && items_sent >= 50) begin
        gap = LONG_HOLD;
        held_once = 1'b1;
      end else begin
        gap = rx_eager ? 0 : $urandom_range(0, GAP_MAX);
      end
      if (gap > 0) out_stall <= 1'b1;
    end
  end

  initial begin
    #1_000_000;
    $display("timeout: block stopped answering");
    $display("rectangle_hit_test_table_unit_tb: done, errors");
    $finish;
  end

endmodule
